>>> rtl/core/nearest_palette_color_map_unit_assert.svh
// Assertion macros shared by the nearest palette color map RTL.
`ifndef NEAREST_PALETTE_COLOR_MAP_UNIT_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_MAP_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define NPCM_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked outside reset.
`define NPCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define NPCM_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define NPCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/nrpcm_pkg.sv
// Shared types and constants of the nearest palette color map.
package nrpcm_pkg;

	localparam int COLOR_W   = 8;
	localparam int PIX_W     = 32;
	localparam int CNT_W     = 9;
	localparam int SHIFT_W   = 5;
	localparam int CFG_IDX_W = 3;
	localparam int SQ_W      = 2 * COLOR_W;
	localparam int DIST_W    = SQ_W + 2;
	localparam int ENTRY_W   = 3 * COLOR_W;

	// Input commands
	localparam logic CMD_MAP   = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_USE_PALETTE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLORS_IN_USE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RED_SHIFT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_SHIFT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_SHIFT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_BITS    = 3'd5;

	// Reset values
	localparam logic [CNT_W-1:0]   RST_COLORS_IN_USE = 9'd256;
	localparam logic [SHIFT_W-1:0] RST_RED_SHIFT     = 5'd16;
	localparam logic [SHIFT_W-1:0] RST_GREEN_SHIFT   = 5'd8;
	localparam logic [SHIFT_W-1:0] RST_BLUE_SHIFT    = 5'd0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic             accept;   // input beat taken this cycle
		logic             write;    // accepted beat is a palette write
		logic             start;    // reset best-match tracking
		logic             issue;    // read one palette entry
		logic [CNT_W-1:0] scan_idx; // entry being read
		logic             load;     // move result into output register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic busy;      // distance pipeline holds entries
		logic out_valid; // output register full
		logic out_ready; // downstream takes the output beat
	} dp_sts_t;

endpackage

>>> rtl/core/nrpcm_if.sv
// Valid/ready channel interfaces for query input and pixel output.
interface nrpcm_req_if import nrpcm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               command;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	logic [7:0]         entry_index;

	modport source (output valid, command, red, green, blue, entry_index, input ready);
	modport sink (input valid, command, red, green, blue, entry_index, output ready);
endinterface

interface nrpcm_rsp_if import nrpcm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;

	modport source (output valid, pixel_value, input ready);
	modport sink (input valid, pixel_value, output ready);
endinterface

>>> rtl/core/nrpcm_ctrl.sv
// Sequencer for map queries, palette scans and palette writes.
`include "nearest_palette_color_map_unit_assert.svh"

module nrpcm_ctrl import nrpcm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_command,
	output logic             req_ready,
	input  logic             use_palette,
	input  logic [CNT_W-1:0] cnt,
	input  dp_sts_t          sts,
	output dp_cmd_t          cmd
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] scan_q, scan_d;

	// State and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q  <= '0;
		end else begin
			state_q <= state_d;
			scan_q  <= scan_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		scan_d       = scan_q;
		req_ready    = 1'b0;
		cmd          = '0;
		cmd.scan_idx = scan_q;
		unique case (state_q)
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
				if (req_valid) begin
					if (req_command == CMD_WRITE) begin
						cmd.write = 1'b1;
					end else if (use_palette) begin
						cmd.start = 1'b1;
						scan_d    = '0;
						state_d   = (cnt == '0) ? ST_FINISH : ST_SCAN;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				scan_d    = scan_q + 1'b1;
				if (scan_q == cnt - 1'b1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!sts.out_valid || sts.out_ready) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Checks
	`NPCM_ASSERT(a_scan_in_range, clk, arst_n, state_q == ST_SCAN, scan_q < cnt, "scan past count")
	`NPCM_ASSERT(a_load_free, clk, arst_n, cmd.load, !sts.out_valid || sts.out_ready, "result overrun")
	`NPCM_ASSERT_NEXT(a_write_stays, clk, arst_n, cmd.accept && cmd.write, state_q == ST_IDLE, "write left idle")

endmodule

>>> rtl/core/nrpcm_dp.sv
// Palette RAM, distance pipeline, best-match tracking and output register.
`include "nearest_palette_color_map_unit_assert.svh"

module nrpcm_dp import nrpcm_pkg::*; #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	input  logic [COLOR_W-1:0] red,
	input  logic [COLOR_W-1:0] green,
	input  logic [COLOR_W-1:0] blue,
	input  logic [7:0]         entry_index,
	input  logic               use_palette,
	input  logic [CNT_W-1:0]   cnt,
	input  logic [SHIFT_W-1:0] red_shift,
	input  logic [SHIFT_W-1:0] green_shift,
	input  logic [SHIFT_W-1:0] blue_shift,
	input  logic [PIX_W-1:0]   alpha_bits,
	nrpcm_rsp_if.source        rsp
);

	// Only the first 256 entries are ever writable; the rest read as zero.
	localparam int MEM_DEPTH = (PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256;
	localparam int AW        = $clog2(MEM_DEPTH);

	logic [ENTRY_W-1:0] mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] valid_q;

	logic [COLOR_W-1:0] qr_q, qg_q, qb_q;

	logic               vld_s1, hit_s1;
	logic [ENTRY_W-1:0] rd_s1;
	logic [CNT_W-1:0]   idx_s1;

	logic               vld_s2;
	logic [SQ_W-1:0]    sqr_s2, sqg_s2, sqb_s2;
	logic [CNT_W-1:0]   idx_s2;

	logic [DIST_W-1:0]  best_dist_q;
	logic [CNT_W-1:0]   best_idx_q;

	logic               out_valid_q;
	logic [PIX_W-1:0]   pixel_q;

	logic               wr_go;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic               in_mem;
	logic [ENTRY_W-1:0] entry;
	logic [COLOR_W-1:0] dr, dg, db;
	logic [DIST_W-1:0]  dist_sum;
	logic [PIX_W-1:0]   packed_pix;

	assign wr_go   = cmd.accept && cmd.write && ({1'b0, entry_index} < cnt);
	assign wr_addr = entry_index[AW-1:0];
	assign rd_addr = cmd.scan_idx[AW-1:0];
	assign in_mem  = cmd.scan_idx < CNT_W'(MEM_DEPTH);

	// Palette RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_go) begin
			mem_q[wr_addr] <= {red, green, blue};
		end
		rd_s1  <= mem_q[rd_addr];
		hit_s1 <= in_mem && valid_q[rd_addr];
		idx_s1 <= cmd.scan_idx;
	end

	// Entry valid bits, pipeline valids and output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_go) begin
				valid_q[wr_addr] <= 1'b1;
			end
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Query capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			qr_q <= red;
			qg_q <= green;
			qb_q <= blue;
		end
	end

	// Stage 2: per-component absolute difference and square
	assign entry = hit_s1 ? rd_s1 : '0;
	assign dr = (entry[23:16] > qr_q) ? entry[23:16] - qr_q : qr_q - entry[23:16];
	assign dg = (entry[15:8] > qg_q) ? entry[15:8] - qg_q : qg_q - entry[15:8];
	assign db = (entry[7:0] > qb_q) ? entry[7:0] - qb_q : qb_q - entry[7:0];

	always_ff @(posedge clk) begin
		sqr_s2 <= SQ_W'(dr) * SQ_W'(dr);
		sqg_s2 <= SQ_W'(dg) * SQ_W'(dg);
		sqb_s2 <= SQ_W'(db) * SQ_W'(db);
		idx_s2 <= idx_s1;
	end

	// Stage 3: sum and keep the first strictly smaller distance
	assign dist_sum = DIST_W'(sqr_s2) + DIST_W'(sqg_s2) + DIST_W'(sqb_s2);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_dist_q <= '1;
			best_idx_q  <= '0;
		end else if (vld_s2 && (dist_sum < best_dist_q)) begin
			best_dist_q <= dist_sum;
			best_idx_q  <= idx_s2;
		end
	end

	// Direct mode packing; bits shifted past the top are dropped
	assign packed_pix = (PIX_W'(qr_q) << red_shift)
		| (PIX_W'(qg_q) << green_shift)
		| (PIX_W'(qb_q) << blue_shift)
		| alpha_bits;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pixel_q <= use_palette ? PIX_W'(best_idx_q) : packed_pix;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.pixel_value = pixel_q;

	assign sts.busy      = vld_s1 || vld_s2;
	assign sts.out_valid = out_valid_q;
	assign sts.out_ready = rsp.ready;

	// Checks
	`NPCM_ASSERT(a_best_in_range, clk, arst_n, cmd.load && use_palette,
		(best_idx_q < cnt) || (best_idx_q == '0), "best index beyond count")
	`NPCM_ASSERT(a_no_write_mid_scan, clk, arst_n, wr_go,
		!vld_s1 && !vld_s2, "palette write during scan")

endmodule

>>> rtl/core/nearest_palette_color_map_unit.sv
// Nearest palette color map: maps an RGB triple to a palette index by
// least squared distance, or packs it directly by configured shifts. A palette
// write goes into the palette RAM as it is taken. A direct mode query moves
// through the finish state into the output register once that is free. A
// palette mode query scans the entries in use one per cycle through the
// single read port of the palette RAM; the next input is taken once the
// result has moved to the output register. The output register holds one
// finished beat, so a slow consumer does not stop the next input. There is
// no clearing pass: the palette reads as zero right after reset.
module nearest_palette_color_map_unit import nrpcm_pkg::*; #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PIX_W-1:0]     cfg_data,
	nrpcm_req_if.sink            req,
	nrpcm_rsp_if.source          rsp
);

	// Search bound is the smaller of the register and the depth
	localparam int CNT_CAP = (PALETTE_DEPTH > 511) ? 511 : PALETTE_DEPTH;

	logic               use_palette_q;
	logic [CNT_W-1:0]   colors_in_use_q;
	logic [SHIFT_W-1:0] red_shift_q, green_shift_q, blue_shift_q;
	logic [PIX_W-1:0]   alpha_bits_q;
	logic [CNT_W-1:0]   cnt;
	dp_cmd_t            cmd;
	dp_sts_t            sts;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_palette_q   <= 1'b0;
			colors_in_use_q <= RST_COLORS_IN_USE;
			red_shift_q     <= RST_RED_SHIFT;
			green_shift_q   <= RST_GREEN_SHIFT;
			blue_shift_q    <= RST_BLUE_SHIFT;
			alpha_bits_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_USE_PALETTE:   use_palette_q   <= cfg_data[0];
				REG_COLORS_IN_USE: colors_in_use_q <= cfg_data[CNT_W-1:0];
				REG_RED_SHIFT:     red_shift_q     <= cfg_data[SHIFT_W-1:0];
				REG_GREEN_SHIFT:   green_shift_q   <= cfg_data[SHIFT_W-1:0];
				REG_BLUE_SHIFT:    blue_shift_q    <= cfg_data[SHIFT_W-1:0];
				REG_ALPHA_BITS:    alpha_bits_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cnt = (colors_in_use_q > CNT_W'(CNT_CAP)) ? CNT_W'(CNT_CAP) : colors_in_use_q;

	nrpcm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_command (req.command),
		.req_ready   (req.ready),
		.use_palette (use_palette_q),
		.cnt         (cnt),
		.sts         (sts),
		.cmd         (cmd)
	);

	nrpcm_dp #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.red         (req.red),
		.green       (req.green),
		.blue        (req.blue),
		.entry_index (req.entry_index),
		.use_palette (use_palette_q),
		.cnt         (cnt),
		.red_shift   (red_shift_q),
		.green_shift (green_shift_q),
		.blue_shift  (blue_shift_q),
		.alpha_bits  (alpha_bits_q),
		.rsp         (rsp)
	);

endmodule
